// File: hw/rtl/jadz_pkg.sv
// Shared types, constants and the output mapping for the joystick dead-zone scaler.
package jadz_pkg;

   localparam int SAMPLE_BITS = 12;
   localparam int FIELD_COUNT = 4;
   localparam int BOUND_BITS  = 12;
   localparam int DZ_BITS     = 10;
   localparam int OFF_BITS    = 11;
   localparam int POS_BITS    = 8;
   localparam int WIDE_BITS   = 14;
   localparam int DIFF_BITS   = 13;
   localparam int MAG_BITS    = 12;
   localparam int Q_BITS      = 7;
   localparam int NUM_BITS    = MAG_BITS + Q_BITS;
   localparam int DEN_BITS    = 13;
   localparam int CMP_BITS    = DEN_BITS + Q_BITS;
   localparam int FRONT_DEPTH = 4;
   localparam int DIV_DEPTH   = Q_BITS + 1;
   localparam int PIPE_DEPTH  = FRONT_DEPTH + DIV_DEPTH + 1;
   localparam int ADDR_BITS   = 5;
   localparam int DATA_BITS   = 32;

   localparam logic signed [BOUND_BITS-1:0] LOWER_RESET = -12'sd1948;
   localparam logic signed [BOUND_BITS-1:0] UPPER_RESET = 12'sd2047;
   localparam logic [DZ_BITS-1:0]           DZ_RESET    = 10'd100;

   localparam logic signed [POS_BITS-1:0] POS_MIN      = -8'sd128;
   localparam logic signed [POS_BITS-1:0] POS_MAX      = 8'sd127;
   localparam logic signed [POS_BITS-1:0] POS_NEG_STEP = -8'sd2;

   typedef enum logic [2:0] {
      REG_LOWER_BOUND,
      REG_UPPER_BOUND,
      REG_DEAD_ZONE,
      REG_LH_OFFSET,
      REG_LV_OFFSET,
      REG_RH_OFFSET,
      REG_RV_OFFSET
   } reg_index_type;

   typedef struct packed {
      logic [SAMPLE_BITS-1:0] left_horizontal_raw;
      logic [SAMPLE_BITS-1:0] left_vertical_raw;
      logic [SAMPLE_BITS-1:0] right_horizontal_raw;
      logic [SAMPLE_BITS-1:0] right_vertical_raw;
   } req_type;

   typedef struct packed {
      logic signed [POS_BITS-1:0] left_horizontal_pos;
      logic signed [POS_BITS-1:0] left_vertical_pos;
      logic signed [POS_BITS-1:0] right_horizontal_pos;
      logic signed [POS_BITS-1:0] right_vertical_pos;
   } rsp_type;

   typedef struct packed {
      logic signed [BOUND_BITS-1:0] lower_bound;
      logic signed [BOUND_BITS-1:0] upper_bound;
      logic [DZ_BITS-1:0]           zone_half;
   } cfg_type;

   typedef struct packed {
      logic                neg;
      logic                zero;
      logic [NUM_BITS-1:0] num;
      logic [DEN_BITS-1:0] den;
   } front_type;

   typedef struct packed {
      logic              neg;
      logic              zero;
      logic              sat;
      logic [Q_BITS-1:0] q;
   } div_type;

   function automatic logic signed [POS_BITS-1:0] pos_map(input div_type d);
      logic signed [POS_BITS-1:0] r;
      if (d.zero) begin
         r = '0;
      end else if (d.neg) begin
         if (d.sat) begin
            r = POS_MIN;
         end else if (d.q == Q_BITS'(1)) begin
            r = POS_NEG_STEP;
         end else begin
            r = POS_BITS'(-$signed({1'b0, d.q}));
         end
      end else if (d.sat) begin
         r = POS_MAX;
      end else begin
         r = $signed({1'b0, d.q});
      end
      return r;
   endfunction

endpackage

// File: hw/rtl/joystick_axis_dead_zone_scaler_top.sv
// Top level of the joystick dead-zone scaler: registers, lanes and result merge.
//
// Each frame of four ADC samples is taken at once, and its four positions
// appear on rsp_payload with rsp_strobe high for one cycle once the frame
// has passed the lanes. One lane per axis works in parallel; each lane is a
// four-stage front end followed by an eight-stage pipelined divider (one
// saturation check, then one quotient bit per stage), and a final merge
// register drives the outputs. busy never rises, so a new frame may be given
// every cycle. Results cannot be held off and must be taken as they appear.
// The user must write registers through the APB-style port only while no frame
// is in flight; the block itself does not enforce it.
module joystick_axis_dead_zone_scaler_top #(
   parameter int AXIS_COUNT = 4
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  jadz_pkg::req_type                   req_payload,
   output logic                                rsp_strobe,
   output jadz_pkg::rsp_type                   rsp_payload,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [jadz_pkg::ADDR_BITS-1:0]      paddr,
   input  logic [jadz_pkg::DATA_BITS-1:0]      pwdata,
   output logic [jadz_pkg::DATA_BITS-1:0]      prdata,
   output logic                                pready
);

   localparam int LANE_COUNT = (AXIS_COUNT < jadz_pkg::FIELD_COUNT) ?
                               AXIS_COUNT : jadz_pkg::FIELD_COUNT;

   logic signed [jadz_pkg::BOUND_BITS-1:0] lower_ff, lower_in;
   logic signed [jadz_pkg::BOUND_BITS-1:0] upper_ff, upper_in;
   logic [jadz_pkg::DZ_BITS-1:0]           dz_ff, dz_in;
   logic signed [jadz_pkg::OFF_BITS-1:0]   offset_ff [jadz_pkg::FIELD_COUNT];
   logic signed [jadz_pkg::OFF_BITS-1:0]   offset_in [jadz_pkg::FIELD_COUNT];
   logic [jadz_pkg::PIPE_DEPTH-1:0]        valid_ff, valid_in;
   jadz_pkg::rsp_type                      rsp_ff, rsp_in;
   jadz_pkg::cfg_type                      cfg;
   jadz_pkg::reg_index_type                reg_index;
   logic                                   wr_en;
   logic [jadz_pkg::SAMPLE_BITS-1:0]       raw [jadz_pkg::FIELD_COUNT];
   logic signed [jadz_pkg::POS_BITS-1:0]   lane_pos [jadz_pkg::FIELD_COUNT];

   assign busy   = 1'b0;
   assign pready = 1'b1;

   assign reg_index = jadz_pkg::reg_index_type'(paddr[jadz_pkg::ADDR_BITS-1:2]);
   assign wr_en     = psel && penable && pwrite && pready;

   always_comb begin
      lower_in  = lower_ff;
      upper_in  = upper_ff;
      dz_in     = dz_ff;
      offset_in = offset_ff;
      if (wr_en) begin
         unique case (reg_index)
            jadz_pkg::REG_LOWER_BOUND: lower_in = pwdata[jadz_pkg::BOUND_BITS-1:0];
            jadz_pkg::REG_UPPER_BOUND: upper_in = pwdata[jadz_pkg::BOUND_BITS-1:0];
            jadz_pkg::REG_DEAD_ZONE:   dz_in = pwdata[jadz_pkg::DZ_BITS-1:0];
            jadz_pkg::REG_LH_OFFSET:   offset_in[0] = pwdata[jadz_pkg::OFF_BITS-1:0];
            jadz_pkg::REG_LV_OFFSET:   offset_in[1] = pwdata[jadz_pkg::OFF_BITS-1:0];
            jadz_pkg::REG_RH_OFFSET:   offset_in[2] = pwdata[jadz_pkg::OFF_BITS-1:0];
            jadz_pkg::REG_RV_OFFSET:   offset_in[3] = pwdata[jadz_pkg::OFF_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_index)
         jadz_pkg::REG_LOWER_BOUND: prdata = jadz_pkg::DATA_BITS'(lower_ff);
         jadz_pkg::REG_UPPER_BOUND: prdata = jadz_pkg::DATA_BITS'(upper_ff);
         jadz_pkg::REG_DEAD_ZONE:   prdata = jadz_pkg::DATA_BITS'(dz_ff);
         jadz_pkg::REG_LH_OFFSET:   prdata = jadz_pkg::DATA_BITS'(offset_ff[0]);
         jadz_pkg::REG_LV_OFFSET:   prdata = jadz_pkg::DATA_BITS'(offset_ff[1]);
         jadz_pkg::REG_RH_OFFSET:   prdata = jadz_pkg::DATA_BITS'(offset_ff[2]);
         jadz_pkg::REG_RV_OFFSET:   prdata = jadz_pkg::DATA_BITS'(offset_ff[3]);
         default:                   prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lower_ff  <= jadz_pkg::LOWER_RESET;
         upper_ff  <= jadz_pkg::UPPER_RESET;
         dz_ff     <= jadz_pkg::DZ_RESET;
         offset_ff <= '{default: '0};
         valid_ff  <= '0;
      end else begin
         lower_ff  <= lower_in;
         upper_ff  <= upper_in;
         dz_ff     <= dz_in;
         offset_ff <= offset_in;
         valid_ff  <= valid_in;
      end
   end

   assign valid_in = {valid_ff[jadz_pkg::PIPE_DEPTH-2:0], start && !busy};

   assign cfg.lower_bound = lower_ff;
   assign cfg.upper_bound = upper_ff;
   assign cfg.zone_half   = dz_ff;

   assign raw[0] = req_payload.left_horizontal_raw;
   assign raw[1] = req_payload.left_vertical_raw;
   assign raw[2] = req_payload.right_horizontal_raw;
   assign raw[3] = req_payload.right_vertical_raw;

   for (genvar i = 0; i < jadz_pkg::FIELD_COUNT; i++) begin : g_lane
      if (i < LANE_COUNT) begin : g_on
         jadz_pkg::front_type front;
         jadz_pkg::div_type   result;

         jadz_front u_front (
            .clock  (clock),
            .raw    (raw[i]),
            .cfg    (cfg),
            .offset (offset_ff[i]),
            .front  (front)
         );

         jadz_div u_div (
            .clock  (clock),
            .front  (front),
            .result (result)
         );

         assign lane_pos[i] = jadz_pkg::pos_map(result);
      end else begin : g_off
         assign lane_pos[i] = '0;
      end
   end

   always_comb begin
      rsp_in.left_horizontal_pos  = lane_pos[0];
      rsp_in.left_vertical_pos    = lane_pos[1];
      rsp_in.right_horizontal_pos = lane_pos[2];
      rsp_in.right_vertical_pos   = lane_pos[3];
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_strobe  = valid_ff[jadz_pkg::PIPE_DEPTH-1];
   assign rsp_payload = rsp_ff;

endmodule

// File: hw/rtl/jadz_front.sv
// Lane front end: centre, clamp, offset, dead zone and divider operands.
module jadz_front (
   input  logic                                    clock,
   input  logic [jadz_pkg::SAMPLE_BITS-1:0]        raw,
   input  jadz_pkg::cfg_type                       cfg,
   input  logic signed [jadz_pkg::OFF_BITS-1:0]    offset,
   output jadz_pkg::front_type                     front
);

   logic signed [jadz_pkg::BOUND_BITS-1:0] centre;
   logic signed [jadz_pkg::BOUND_BITS-1:0] lower;
   logic signed [jadz_pkg::BOUND_BITS-1:0] upper;
   logic signed [jadz_pkg::DIFF_BITS-1:0]  dz_s;

   logic signed [jadz_pkg::BOUND_BITS-1:0] c_ff, c_in;
   logic signed [jadz_pkg::OFF_BITS-1:0]   off_ff;
   logic signed [jadz_pkg::WIDE_BITS-1:0]  lb1_ff, lb1_in, ub1_ff, ub1_in;
   logic signed [jadz_pkg::DIFF_BITS-1:0]  d_ff, d_in;
   logic signed [jadz_pkg::WIDE_BITS-1:0]  lb2_ff, ub2_ff;
   logic signed [jadz_pkg::DIFF_BITS-1:0]  v_ff, v_in;
   logic signed [jadz_pkg::WIDE_BITS-1:0]  lb3_ff, ub3_ff;
   logic [jadz_pkg::MAG_BITS-1:0]          mag;
   logic [jadz_pkg::NUM_BITS-1:0]          mag_ext;
   jadz_pkg::front_type                    front_ff, front_in;

   always_comb begin
      lower  = cfg.lower_bound;
      upper  = cfg.upper_bound;
      centre = $signed({~raw[jadz_pkg::SAMPLE_BITS-1], raw[jadz_pkg::SAMPLE_BITS-2:0]});
      if (centre < lower) begin
         c_in = lower;
      end else if (centre > upper) begin
         c_in = upper;
      end else begin
         c_in = centre;
      end
      lb1_in = jadz_pkg::WIDE_BITS'(lower) - jadz_pkg::WIDE_BITS'(offset)
               + $signed({4'b0000, cfg.zone_half});
      ub1_in = jadz_pkg::WIDE_BITS'(upper) - jadz_pkg::WIDE_BITS'(offset)
               - $signed({4'b0000, cfg.zone_half});
   end

   always_comb begin
      d_in = jadz_pkg::DIFF_BITS'(c_ff) - jadz_pkg::DIFF_BITS'(off_ff);
   end

   always_comb begin
      dz_s = $signed({3'b000, cfg.zone_half});
      if (d_ff < dz_s && d_ff > -dz_s) begin
         v_in = '0;
      end else if (d_ff >= dz_s) begin
         v_in = d_ff - dz_s;
      end else begin
         v_in = d_ff + dz_s;
      end
   end

   always_comb begin
      front_in.neg = v_ff[jadz_pkg::DIFF_BITS-1];
      if (front_in.neg) begin
         mag           = jadz_pkg::MAG_BITS'(-v_ff);
         mag_ext       = jadz_pkg::NUM_BITS'(mag);
         front_in.num  = mag_ext << jadz_pkg::Q_BITS;
         front_in.den  = jadz_pkg::DEN_BITS'(-lb3_ff);
         front_in.zero = !lb3_ff[jadz_pkg::WIDE_BITS-1];
      end else begin
         mag           = jadz_pkg::MAG_BITS'(v_ff);
         mag_ext       = jadz_pkg::NUM_BITS'(mag);
         front_in.num  = (mag_ext << jadz_pkg::Q_BITS) - mag_ext;
         front_in.den  = jadz_pkg::DEN_BITS'(ub3_ff);
         front_in.zero = ub3_ff[jadz_pkg::WIDE_BITS-1] || (ub3_ff == '0);
      end
   end

   always_ff @(posedge clock) begin
      c_ff     <= c_in;
      off_ff   <= offset;
      lb1_ff   <= lb1_in;
      ub1_ff   <= ub1_in;
      d_ff     <= d_in;
      lb2_ff   <= lb1_ff;
      ub2_ff   <= ub1_ff;
      v_ff     <= v_in;
      lb3_ff   <= lb2_ff;
      ub3_ff   <= ub2_ff;
      front_ff <= front_in;
   end

   assign front = front_ff;

endmodule

// File: hw/rtl/jadz_div.sv
// Lane divider: saturation check then one restoring quotient bit per stage.
module jadz_div (
   input  logic                clock,
   input  jadz_pkg::front_type front,
   output jadz_pkg::div_type   result
);

   localparam int DEPTH = jadz_pkg::DIV_DEPTH;

   logic [jadz_pkg::NUM_BITS-1:0] rem_ff  [DEPTH];
   logic [jadz_pkg::DEN_BITS-1:0] den_ff  [DEPTH];
   logic [jadz_pkg::Q_BITS-1:0]   q_ff    [DEPTH];
   logic                          neg_ff  [DEPTH];
   logic                          zero_ff [DEPTH];
   logic                          sat_ff  [DEPTH];
   logic                          sat_in;

   assign sat_in = jadz_pkg::CMP_BITS'(front.num)
                   >= (jadz_pkg::CMP_BITS'(front.den) << jadz_pkg::Q_BITS);

   always_ff @(posedge clock) begin
      rem_ff[0]  <= front.num;
      den_ff[0]  <= front.den;
      q_ff[0]    <= '0;
      neg_ff[0]  <= front.neg;
      zero_ff[0] <= front.zero;
      sat_ff[0]  <= sat_in;
   end

   for (genvar s = 1; s < DEPTH; s++) begin : g_stage
      localparam int SHIFT = DEPTH - 1 - s;
      logic [jadz_pkg::CMP_BITS-1:0] shifted;
      logic                          take;
      logic [jadz_pkg::NUM_BITS-1:0] rem_in;

      always_comb begin
         shifted = jadz_pkg::CMP_BITS'(den_ff[s-1]) << SHIFT;
         take    = jadz_pkg::CMP_BITS'(rem_ff[s-1]) >= shifted;
         rem_in  = take ? jadz_pkg::NUM_BITS'(jadz_pkg::CMP_BITS'(rem_ff[s-1]) - shifted)
                        : rem_ff[s-1];
      end

      always_ff @(posedge clock) begin
         rem_ff[s]  <= rem_in;
         den_ff[s]  <= den_ff[s-1];
         q_ff[s]    <= {q_ff[s-1][jadz_pkg::Q_BITS-2:0], take};
         neg_ff[s]  <= neg_ff[s-1];
         zero_ff[s] <= zero_ff[s-1];
         sat_ff[s]  <= sat_ff[s-1];
      end
   end

   assign result.neg  = neg_ff[DEPTH-1];
   assign result.zero = zero_ff[DEPTH-1];
   assign result.sat  = sat_ff[DEPTH-1];
   assign result.q    = q_ff[DEPTH-1];

endmodule
